@@ sv/ccl_pkg.sv @@
// Shared constants and types for the column occlusion clipper.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none
package ccl_pkg;

  localparam int unsigned SCREEN_WIDTH = 128;  // default screen width, 16..128
  localparam int unsigned COL_IN_W     = 9;    // signed column fields of a clip beat
  localparam int unsigned SPAN_W       = 8;    // span fields of a result beat

  // Input kind codes
  localparam logic KIND_NEW_FRAME = 1'b0;
  localparam logic KIND_CLIP      = 1'b1;

  // Bitmap control from the run finder
  typedef struct packed {
    logic clear;  // open every column
    logic shift;  // rotate one column
    logic mark;   // occlude the column rotating out
  } bm_ctrl_t;

endpackage
`default_nettype wire

@@ sv/ccl_in_if.sv @@
// Clip-item channel: valid/ready handshake with the clip fields.
// Depends on ccl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ccl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [ccl_pkg::COL_IN_W-1:0]   start_col;
  logic signed [ccl_pkg::COL_IN_W-1:0]   end_col;
  logic                                  solid;

  modport source (output valid, kind, start_col, end_col, solid, input ready);
  modport sink   (input valid, kind, start_col, end_col, solid, output ready);
endinterface
`default_nettype wire

@@ sv/ccl_out_if.sv @@
// Span-result channel: valid/ready handshake with the span fields.
// Depends on ccl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ccl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          visible;
  logic [ccl_pkg::SPAN_W-1:0]    span_start;
  logic [ccl_pkg::SPAN_W-1:0]    span_end;
  logic                          last;

  modport source (output valid, visible, span_start, span_end, last, input ready);
  modport sink   (input valid, visible, span_start, span_end, last, output ready);
endinterface
`default_nettype wire

@@ sv/ccl_bitmap.sv @@
// Occlusion bitmap held as a circular shift register, one bit per column.
// Depends on ccl_pkg (bm_ctrl_t).
`timescale 1ns / 1ps
`default_nettype none
module ccl_bitmap #(
  parameter int unsigned SCREEN_WIDTH = ccl_pkg::SCREEN_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccl_pkg::bm_ctrl_t ctrl_i,
  output logic                   occ_bit_o
);

  logic [SCREEN_WIDTH-1:0] occ_q, occ_d;

  // Bit 0 is the column under scan; it re-enters at the top.
  always_comb begin
    occ_d = occ_q;
    if (ctrl_i.clear) begin
      occ_d = '0;
    end else if (ctrl_i.shift) begin
      occ_d = {occ_q[0] | ctrl_i.mark, occ_q[SCREEN_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign occ_bit_o = occ_q[0];

endmodule
`default_nettype wire

@@ sv/ccl_runfind.sv @@
// Run finder: clamps the range, walks one column per cycle unless stalled,
// holds one run back to tag the last beat, and drives the output register.
// Depends on ccl_pkg, ccl_in_if and ccl_out_if.
`timescale 1ns / 1ps
`default_nettype none
module ccl_runfind #(
  parameter int unsigned SCREEN_WIDTH = ccl_pkg::SCREEN_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  ccl_in_if.sink                  in_i,
  ccl_out_if.source               out_o,
  input  wire logic               occ_bit_i,
  output ccl_pkg::bm_ctrl_t       bm_ctrl_o
);

  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned CIW   = ccl_pkg::COL_IN_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic             solid_q, solid_d;
  logic             in_run_q, in_run_d;
  logic [COL_W-1:0] run_start_q, run_start_d;
  logic             held_v_q, held_v_d;
  logic [COL_W-1:0] held_s_q, held_s_d, held_e_q, held_e_d;

  logic                        ov_q, ov_d;
  logic                        vis_q, vis_d, last_q, last_d;
  logic [ccl_pkg::SPAN_W-1:0]  ss_q, ss_d, se_q, se_d;

  logic [COL_W-1:0] lo_clamp, hi_clamp;
  logic             emit_ok, in_rng, open_col, closing, accept;

  // Clamp signed columns to [0, SCREEN_WIDTH]
  always_comb begin
    if (in_i.start_col < 0) begin
      lo_clamp = '0;
    end else if ({1'b0, in_i.start_col} > (CIW + 1)'(SCREEN_WIDTH)) begin
      lo_clamp = COL_W'(SCREEN_WIDTH);
    end else begin
      lo_clamp = COL_W'(in_i.start_col);
    end
    if (in_i.end_col < 0) begin
      hi_clamp = '0;
    end else if ({1'b0, in_i.end_col} > (CIW + 1)'(SCREEN_WIDTH)) begin
      hi_clamp = COL_W'(SCREEN_WIDTH);
    end else begin
      hi_clamp = COL_W'(in_i.end_col);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign emit_ok    = !ov_q || out_o.ready;
  assign in_rng     = (col_q >= lo_q) && (col_q < hi_q);
  assign open_col   = in_rng && !occ_bit_i;
  assign closing    = in_run_q && !open_col;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    solid_d     = solid_q;
    in_run_d    = in_run_q;
    run_start_d = run_start_q;
    held_v_d    = held_v_q;
    held_s_d    = held_s_q;
    held_e_d    = held_e_q;
    bm_ctrl_o   = '0;

    ov_d   = ov_q && !out_o.ready;
    vis_d  = vis_q;
    ss_d   = ss_q;
    se_d   = se_q;
    last_d = last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          col_d    = '0;
          in_run_d = 1'b0;
          held_v_d = 1'b0;
          state_d  = ST_SCAN;
          lo_d     = lo_clamp;
          hi_d     = hi_clamp;
          solid_d  = in_i.solid;
          if (in_i.kind == ccl_pkg::KIND_NEW_FRAME) begin
            bm_ctrl_o.clear = 1'b1;
            state_d         = ST_FLUSH;
          end
        end
      end
      ST_SCAN: begin
        // Stall only when a finished run must push the held one out
        if (!(closing && held_v_q && !emit_ok)) begin
          bm_ctrl_o.shift = 1'b1;
          bm_ctrl_o.mark  = solid_q && in_rng;
          if (closing) begin
            if (held_v_q) begin
              ov_d   = 1'b1;
              vis_d  = 1'b1;
              ss_d   = ccl_pkg::SPAN_W'(held_s_q);
              se_d   = ccl_pkg::SPAN_W'(held_e_q);
              last_d = 1'b0;
            end
            held_v_d = 1'b1;
            held_s_d = run_start_q;
            held_e_d = col_q;
            in_run_d = 1'b0;
          end
          if (open_col && !in_run_q) begin
            run_start_d = col_q;
            in_run_d    = 1'b1;
          end
          col_d = col_q + 1'b1;
          if (col_q == COL_W'(SCREEN_WIDTH - 1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (in_run_q) begin
          // run reaching the right screen edge
          if (!held_v_q || emit_ok) begin
            if (held_v_q) begin
              ov_d   = 1'b1;
              vis_d  = 1'b1;
              ss_d   = ccl_pkg::SPAN_W'(held_s_q);
              se_d   = ccl_pkg::SPAN_W'(held_e_q);
              last_d = 1'b0;
            end
            held_v_d = 1'b1;
            held_s_d = run_start_q;
            held_e_d = COL_W'(SCREEN_WIDTH);
            in_run_d = 1'b0;
          end
        end else if (emit_ok) begin
          ov_d     = 1'b1;
          vis_d    = held_v_q;
          ss_d     = held_v_q ? ccl_pkg::SPAN_W'(held_s_q) : '0;
          se_d     = held_v_q ? ccl_pkg::SPAN_W'(held_e_q) : '0;
          last_d   = 1'b1;
          held_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      in_run_q <= 1'b0;
      held_v_q <= 1'b0;
      ov_q     <= 1'b0;
      col_q    <= '0;
    end else begin
      state_q  <= state_d;
      in_run_q <= in_run_d;
      held_v_q <= held_v_d;
      ov_q     <= ov_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    solid_q     <= solid_d;
    run_start_q <= run_start_d;
    held_s_q    <= held_s_d;
    held_e_q    <= held_e_d;
    vis_q       <= vis_d;
    ss_q        <= ss_d;
    se_q        <= se_d;
    last_q      <= last_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.visible    = vis_q;
  assign out_o.span_start = ss_q;
  assign out_o.span_end   = se_q;
  assign out_o.last       = last_q;

endmodule
`default_nettype wire

@@ sv/column_occlusion_clipper.sv @@
// Column occlusion clipper. A clip beat scans every column through the occlusion
// shift register, one per cycle unless a closed run waits on a full output; its
// last result loads into the output register in the flush state after the scan.
// A new beat is taken only once the last result of the one before has loaded.
// Reset (rst_ni low, async) opens every column and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module column_occlusion_clipper #(
  parameter int unsigned SCREEN_WIDTH = ccl_pkg::SCREEN_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ccl_in_if.sink    in_i,
  ccl_out_if.source out_o
);

  // Control from the run finder to the bitmap: clear, rotate, mark.
  ccl_pkg::bm_ctrl_t bm_ctrl;
  // Occlusion bit of the column under scan.
  logic              occ_bit;

  // Occlusion state: one bit per column, rotated past the scanner so the
  // logic per cycle stays one bit wide regardless of screen width.
  ccl_bitmap #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (bm_ctrl),
    .occ_bit_o (occ_bit)
  );

  // Scan control: finds maximal open runs inside the clamped range, keeps
  // one run back so the final beat can carry last, and marks solid ranges
  // as they rotate by. Marking during the scan is safe: each column is
  // read once before it is written, and an item with no open run only
  // covers columns that are already occluded.
  ccl_runfind #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_runfind (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .occ_bit_i (occ_bit),
    .bm_ctrl_o (bm_ctrl)
  );

endmodule
`default_nettype wire

@@ tb/column_occlusion_clipper_tb.sv @@
// Self-checking testbench for column_occlusion_clipper: directed and random clip beats,
// with a scoreboard fed by a column-bitmap predictor.
// Depends on ccl_pkg, ccl_in_if, ccl_out_if and the clipper RTL.
`timescale 1ns / 1ps
module column_occlusion_clipper_tb;

  localparam int unsigned SCR_W      = ccl_pkg::SCREEN_WIDTH;
  localparam int          NUM_ITEMS  = 470;
  localparam int          QUIET_MAX  = 4000;  // cycles with no beat on either side
  localparam int          MAX_REPORT = 10;

  // One pending clip beat; hold = wait for every expected span before sending it.
  typedef struct {
    logic                                kind;
    logic signed [ccl_pkg::COL_IN_W-1:0] start_col;
    logic signed [ccl_pkg::COL_IN_W-1:0] end_col;
    logic                                solid;
    bit                                  hold;
  } clip_t;

  typedef struct packed {
    logic                       visible;
    logic [ccl_pkg::SPAN_W-1:0] span_start;
    logic [ccl_pkg::SPAN_W-1:0] span_end;
    logic                       last;
  } span_t;

  logic clk_i;
  logic rst_ni;

  ccl_in_if  in_if ();
  ccl_out_if out_if ();

  column_occlusion_clipper #(
    .SCREEN_WIDTH(SCR_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  clip_t          clip_q[$];  // beats still to be sent
  span_t          span_q[$];  // spans the clipper still owes us
  logic [SCR_W-1:0] occluded;  // predicted occlusion bitmap
  int             num_items;
  int             in_beats;
  int             err_cnt;
  int             quiet_cycles;
  logic           in_taken;   // clip beat accepted at the last rising edge

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Queue helpers
  // ---------------------------------------------------------------------------
  function automatic void add_clip(clip_t c);
    clip_q.insert(clip_q.size(), c);
  endfunction

  function automatic void add_span(span_t s);
    span_q.insert(span_q.size(), s);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sign-extend the 9-bit column and clamp to the screen.
  function automatic int clamp_col(logic signed [ccl_pkg::COL_IN_W-1:0] v);
    int c;
    c = v;
    if (c < 0) c = 0;
    if (c > int'(SCR_W)) c = int'(SCR_W);
    return c;
  endfunction

  // Queue the spans one clip beat produces and update the occlusion bitmap.
  function automatic void predict_spans(clip_t it);
    int    lo;
    int    hi;
    int    x;
    int    run_lo;
    int    runs;
    span_t sp;
    if (it.kind == ccl_pkg::KIND_NEW_FRAME) begin
      occluded = '0;
      add_span(span_t'{1'b0, '0, '0, 1'b1});
      return;
    end
    lo   = clamp_col(it.start_col);
    hi   = clamp_col(it.end_col);
    runs = 0;
    x    = lo;
    while (x < hi) begin
      if (occluded[x]) begin
        x++;
        continue;
      end
      run_lo = x;
      while (x < hi && !occluded[x]) x++;
      sp = '{1'b1, run_lo[ccl_pkg::SPAN_W-1:0], x[ccl_pkg::SPAN_W-1:0], 1'b0};
      add_span(sp);
      runs++;
    end
    if (runs == 0) begin
      // empty, inverted or fully hidden range: one blank span, bitmap untouched
      add_span(span_t'{1'b0, '0, '0, 1'b1});
      return;
    end
    // occlusion is applied only after all runs are found
    if (it.solid)
      for (x = lo; x < hi; x++) occluded[x] = 1'b1;
    span_q[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic clip_t mk_clip(logic kind, int lo, int hi, logic solid, bit hold);
    clip_t c;
    c.kind      = kind;
    c.start_col = lo[ccl_pkg::COL_IN_W-1:0];
    c.end_col   = hi[ccl_pkg::COL_IN_W-1:0];
    c.solid     = solid;
    c.hold      = hold;
    return c;
  endfunction

  // Mostly well-formed ranges on screen; some reach off the edges, some are raw noise.
  function automatic clip_t rand_clip();
    int r;
    int lo;
    int w;
    r = $urandom_range(0, 99);
    if (r < 8)
      return mk_clip(1'($urandom), $urandom, $urandom, 1'($urandom), 1'b0);
    lo = $urandom_range(0, SCR_W - 1);
    w  = (r < 70) ? $urandom_range(1, 16) : $urandom_range(0, SCR_W);
    if (r < 14) lo = lo - 4;        // left edge, may go negative
    if (r >= 95) w = -$urandom_range(0, 8);  // inverted or empty
    return mk_clip(ccl_pkg::KIND_CLIP, lo, lo + w, ($urandom_range(0, 9) < 7), 1'b0);
  endfunction

  // Idle rates by test phase: sender-heavy, receiver-heavy, then none.
  function automatic int tx_idle_pct();
    if (in_beats * 3 < num_items) return 31;
    if (in_beats * 3 < num_items * 2) return 67;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (in_beats * 3 < num_items) return 67;
    if (in_beats * 3 < num_items * 2) return 31;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    bit    send;
    clip_t nxt;
    if (rst_ni) begin
      // the current beat holds until accepted
      if (!in_if.valid || in_taken) begin
        send = 1'b0;
        if (clip_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
          // a held beat waits until the clipper has drained
          if (!clip_q[0].hold || span_q.size() == 0) send = 1'b1;
        end
        if (send) begin
          nxt = clip_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.kind      <= nxt.kind;
          in_if.start_col <= nxt.start_col;
          in_if.end_col   <= nxt.end_col;
          in_if.solid     <= nxt.solid;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge, predicts and checks
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    clip_t got_in;
    span_t got;
    span_t want;
    bit    any_beat;
    if (rst_ni) begin
      any_beat = 1'b0;
      if (in_if.valid && in_if.ready) begin
        got_in.kind      = in_if.kind;
        got_in.start_col = in_if.start_col;
        got_in.end_col   = in_if.end_col;
        got_in.solid     = in_if.solid;
        got_in.hold      = 1'b0;
        predict_spans(got_in);
        in_beats++;
        any_beat = 1'b1;
      end
      in_taken <= in_if.valid && in_if.ready;

      if (out_if.valid && out_if.ready) begin
        any_beat = 1'b1;
        got = '{out_if.visible, out_if.span_start, out_if.span_end, out_if.last};
        if (span_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORT)
            $display("%0t: unexpected span beat vis=%0d %0d..%0d last=%0d", $realtime,
                     got.visible, got.span_start, got.span_end, got.last);
        end else begin
          want = span_q.pop_front();
          if (got.visible !== want.visible || got.span_start !== want.span_start ||
              got.span_end !== want.span_end || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORT) begin
              $display("%0t: span mismatch exp vis=%0d %0d..%0d last=%0d", $realtime,
                       want.visible, want.span_start, want.span_end, want.last);
              $display("%0t:               got vis=%0d %0d..%0d last=%0d", $realtime,
                       got.visible, got.span_start, got.span_end, got.last);
            end
          end
        end
      end

      // watchdog: count cycles where nothing moves on either channel
      if (any_beat) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of test
  // ---------------------------------------------------------------------------
  initial begin
    int  lo;
    int  x;
    bit  comb_done;
    bit  timed_out;

    // known values on every input from time zero
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = ccl_pkg::KIND_NEW_FRAME;
    in_if.start_col  = '0;
    in_if.end_col    = '0;
    in_if.solid      = 1'b0;
    out_if.ready     = 1'b0;
    in_taken         = 1'b0;
    occluded         = '0;
    in_beats         = 0;
    err_cnt          = 0;
    quiet_cycles     = 0;
    comb_done        = 1'b0;

    // Directed part
    add_clip(mk_clip(ccl_pkg::KIND_NEW_FRAME, 77, -20, 1'b1, 1'b0)); // other fields ignored
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 0, SCR_W, 1'b0, 1'b0));     // whole screen open
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 10, 20, 1'b1, 1'b0));       // first wall
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 0, SCR_W, 1'b0, 1'b0));     // two runs around it
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 15, 25, 1'b1, 1'b0));       // partly hidden
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 10, 25, 1'b1, 1'b0));       // fully hidden
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 30, 29, 1'b1, 1'b0));       // inverted
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 40, 40, 1'b1, 1'b0));       // empty
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, -1, 5, 1'b1, 1'b1));        // off the left edge
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 120, SCR_W, 1'b1, 1'b0));   // right edge
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 100, 255, 1'b0, 1'b0));     // far past the right edge
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, -256, 255, 1'b0, 1'b0));    // both field extremes
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 255, -256, 1'b1, 1'b0));    // inverted extremes
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, SCR_W, -1, 1'b1, 1'b0));    // inverted at the edges
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, -1, SCR_W, 1'b1, 1'b0));    // close the screen
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 0, SCR_W, 1'b0, 1'b0));     // nothing left
    add_clip(mk_clip(ccl_pkg::KIND_NEW_FRAME, -256, 255, 1'b0, 1'b1));
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 60, 61, 1'b1, 1'b0));       // single column
    add_clip(mk_clip(ccl_pkg::KIND_CLIP, 59, 62, 1'b0, 1'b0));       // runs of one column
    add_clip(mk_clip(ccl_pkg::KIND_NEW_FRAME, 0, 0, 1'b0, 1'b0));

    // Random part: frames of mostly well-formed walls, with a comb frame once for the
    // maximum span count
    while (clip_q.size() < NUM_ITEMS) begin
      add_clip(mk_clip(ccl_pkg::KIND_NEW_FRAME, $urandom, $urandom, 1'($urandom),
                       ($urandom_range(0, 5) == 0)));
      if (!comb_done && clip_q.size() > 150) begin
        comb_done = 1'b1;
        lo = $urandom_range(0, 1);  // occlude even or odd columns
        for (x = lo; x < int'(SCR_W); x += 2)
          add_clip(mk_clip(ccl_pkg::KIND_CLIP, x, x + 1, 1'b1, 1'b0));
        add_clip(mk_clip(ccl_pkg::KIND_CLIP, -1, SCR_W, 1'b0, 1'b0));
        add_clip(mk_clip(ccl_pkg::KIND_CLIP, -1, SCR_W, 1'b1, 1'b0));
        add_clip(mk_clip(ccl_pkg::KIND_CLIP, 0, SCR_W, 1'b0, 1'b0));
      end
      repeat ($urandom_range(4, 24)) add_clip(rand_clip());
    end
    num_items = clip_q.size();

    // reset held low from time zero, released at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // run until every beat is sent and every span has arrived
    do @(posedge clk_i);
    while (!(clip_q.size() == 0 && !in_if.valid && span_q.size() == 0) &&
           quiet_cycles < QUIET_MAX);
    timed_out = (quiet_cycles >= QUIET_MAX);

    // let any stray span show up
    if (!timed_out) repeat (2 * SCR_W + 16) @(posedge clk_i);

    if (!timed_out && err_cnt == 0 && span_q.size() == 0)
      $display("column_occlusion_clipper_tb: PASS");
    else
      $display("column_occlusion_clipper_tb: FAIL");
    $finish;
  end

endmodule
